FILE: rtl/core/tkms_pkg.sv
// ----------------------------------------------------------------------------
// tkms_pkg
// shared widths, defaults and controller/datapath handshake types for the
// triple-key table search core
// ----------------------------------------------------------------------------
package tkms_pkg;

  localparam int TKMS_DEPTH_DEFAULT = 1024;

  localparam int CNT_W   = 11;
  localparam int SLOT_W  = 10;
  localparam int CLASS_W = 16;
  localparam int NAME_W  = 32;
  localparam int PROTO_W = 16;
  localparam int KEY_W   = CLASS_W + NAME_W + PROTO_W;

  // request kind codes
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic wr;
    logic start;
    logic probe;
    logic judge;
    logic out_load;
  } tkms_cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
  } tkms_sts_t;

endpackage

FILE: rtl/core/tkms_if.sv
// ----------------------------------------------------------------------------
// tkms_if
// valid/ready channels for request transactions and search results
// ----------------------------------------------------------------------------
interface tkms_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [tkms_pkg::SLOT_W-1:0]  entry_slot;
  logic [tkms_pkg::CLASS_W-1:0] class_index;
  logic [tkms_pkg::NAME_W-1:0]  name_index;
  logic [tkms_pkg::PROTO_W-1:0] proto_index;

  modport source (
    output valid, kind, entry_slot, class_index, name_index, proto_index,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_slot, class_index, name_index, proto_index,
    output ready
  );
endinterface

interface tkms_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [tkms_pkg::SLOT_W-1:0] match_slot;

  modport source (
    output valid, found, match_slot,
    input  ready
  );
  modport sink (
    input  valid, found, match_slot,
    output ready
  );
endinterface

FILE: rtl/core/tkms_ctrl.sv
// ----------------------------------------------------------------------------
// tkms_ctrl
// sequencer for table writes and the search: one memory probe and one compare per step,
// result handoff into the output register
// ----------------------------------------------------------------------------
module tkms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output tkms_pkg::tkms_cmd_t cmd,
  input  tkms_pkg::tkms_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PROBE = 4'b0010,
    S_JUDGE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == tkms_pkg::KIND_LOOKUP) begin
            cmd.start = 1'b1;
            state_nxt = S_PROBE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_PROBE: begin
        if (sts.empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        cmd.judge = 1'b1;
        state_nxt = sts.hit ? S_DONE : S_PROBE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_lookup_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == tkms_pkg::KIND_LOOKUP) |=> (state_r == S_PROBE))
    else $error("lookup transaction did not start a search");

  a_load_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("result loaded over a pending transaction");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result transaction withdrawn before it was taken");

endmodule

FILE: rtl/core/tkms_dp.sv
// ----------------------------------------------------------------------------
// tkms_dp
// key table memory, search bounds, key compare and result registers
// ----------------------------------------------------------------------------
module tkms_dp #(
  parameter int TABLE_DEPTH = tkms_pkg::TKMS_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tkms_pkg::tkms_cmd_t           cmd,
  output tkms_pkg::tkms_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [tkms_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic [tkms_pkg::SLOT_W-1:0]   in_entry_slot,
  input  logic [tkms_pkg::CLASS_W-1:0]  in_class_index,
  input  logic [tkms_pkg::NAME_W-1:0]   in_name_index,
  input  logic [tkms_pkg::PROTO_W-1:0]  in_proto_index,
  output logic                          out_found,
  output logic [tkms_pkg::SLOT_W-1:0]   out_match_slot
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = $clog2(TABLE_DEPTH + 1);

  logic [tkms_pkg::KEY_W-1:0]  mem [TABLE_DEPTH];
  logic [tkms_pkg::KEY_W-1:0]  rd_q;
  logic [tkms_pkg::KEY_W-1:0]  key_in;
  logic [tkms_pkg::KEY_W-1:0]  key_r;
  logic [tkms_pkg::CNT_W-1:0]  count_r;
  logic [SW-1:0]               eff_cnt;
  logic [SW-1:0]               lo_r, hi_r, mid_r;
  logic [SW:0]                 mid_sum;
  logic [SW-1:0]               mid_w;
  logic                        found_r;
  logic [tkms_pkg::SLOT_W-1:0] match_r;
  logic                        out_found_r;
  logic [tkms_pkg::SLOT_W-1:0] out_slot_r;
  logic                        key_gt, key_lt;
  logic                        slot_ok;

  assign key_in  = {in_class_index, in_name_index, in_proto_index};
  assign slot_ok = (32'(in_entry_slot) < TABLE_DEPTH);

  always_comb begin
    if (32'(count_r) > TABLE_DEPTH) begin
      eff_cnt = SW'(TABLE_DEPTH);
    end else begin
      eff_cnt = SW'(count_r);
    end
  end

  // floor((lo + hi - 1) / 2) with hi held exclusive
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - (SW + 1)'(1);
  assign mid_w   = mid_sum[SW:1];

  assign key_gt    = (key_r > rd_q);
  assign key_lt    = (key_r < rd_q);
  assign sts.empty = !(lo_r < hi_r);
  assign sts.hit   = !key_gt && !key_lt;

  always_ff @(posedge clk) begin
    if (cmd.wr && slot_ok) begin
      mem[AW'(in_entry_slot)] <= key_in;
    end
    if (cmd.probe) begin
      rd_q <= mem[mid_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r   <= key_in;
      lo_r    <= '0;
      hi_r    <= eff_cnt;
      found_r <= 1'b0;
      match_r <= '0;
    end
    if (cmd.probe) begin
      mid_r <= mid_w;
    end
    if (cmd.judge) begin
      if (key_gt) begin
        lo_r <= mid_r + SW'(1);
      end else if (key_lt) begin
        hi_r <= mid_r;
      end else begin
        found_r <= 1'b1;
        match_r <= tkms_pkg::SLOT_W'(mid_r);
      end
    end
    if (cmd.out_load) begin
      out_found_r <= found_r;
      out_slot_r  <= match_r;
    end
  end

  assign out_found      = out_found_r;
  assign out_match_slot = out_slot_r;

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> (lo_r < hi_r))
    else $error("probe issued on an empty search range");

  a_judge_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.judge |-> $past(cmd.probe))
    else $error("compare without a preceding memory read");

  a_range_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.judge && !sts.hit) |=> ((hi_r - lo_r) < $past(hi_r - lo_r)))
    else $error("search range did not shrink after a miss");

endmodule

FILE: rtl/core/triple_key_method_table_search_core.sv
// ----------------------------------------------------------------------------
// triple_key_method_table_search_core
// binary search over a table of (class, name, prototype) keys, compared
// unsigned and lexicographically, with single-entry write transactions
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  in_ch    sink       kind, entry_slot, class_index, name_index, proto_index
//  out_ch   source     found, match_slot (one per lookup, none per write)
//  cfg_*    write      table_count
//
//  a write transaction is taken and the block stays ready for the next one
//  a lookup does a registered memory read, then a compare, per probe, up to
//  11 probes at 1024 entries, then loads the result into the output register
//  in_ready is low while a lookup runs; a finished result waits in the
//  output register and the next transaction is taken meanwhile
//  reset clears table_count and the control state; table contents are not
//  cleared and need no clearing pass
// ----------------------------------------------------------------------------
module triple_key_method_table_search_core #(
  parameter int TABLE_DEPTH = tkms_pkg::TKMS_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tkms_req_if.sink                   in_ch,
  tkms_rsp_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [tkms_pkg::CNT_W-1:0] cfg_wdata
);

  tkms_pkg::tkms_cmd_t cmd;
  tkms_pkg::tkms_sts_t sts;

  tkms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  tkms_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_entry_slot  (in_ch.entry_slot),
    .in_class_index (in_ch.class_index),
    .in_name_index  (in_ch.name_index),
    .in_proto_index (in_ch.proto_index),
    .out_found      (out_ch.found),
    .out_match_slot (out_ch.match_slot)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// sorted and unsorted key tables loaded through write transactions,
// table_count set between phases while the core is idle, lookup
// transactions checked in order against a mirror of the table, random gaps
// on the request channel and stalls on the result channel
// ----------------------------------------------------------------------------
module testbench;

  localparam int TABLE_DEPTH = tkms_pkg::TKMS_DEPTH_DEFAULT;
  localparam int EXP_DEPTH   = 256;
  localparam int STEP_MAX    = 32;
  localparam logic [tkms_pkg::KEY_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    logic                        found;
    logic [tkms_pkg::SLOT_W-1:0] match_slot;
  } result_t;

  typedef enum logic [1:0] {OP_WRITE, OP_LOOKUP, OP_COUNT} step_op_t;

  typedef struct packed {
    step_op_t                    op;
    logic [tkms_pkg::SLOT_W-1:0] slot;
    logic [tkms_pkg::KEY_W-1:0]  key;
    logic [tkms_pkg::CNT_W-1:0]  cnt;
    logic                        typed;
    result_t                     exp;
  } step_t;

  localparam result_t NO_MATCH = '{found: 1'b0, match_slot: '0};

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [tkms_pkg::CNT_W-1:0] cfg_wdata;

  tkms_req_if req ();
  tkms_rsp_if rsp ();

  triple_key_method_table_search_core #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req),
    .out_ch    (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [tkms_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [tkms_pkg::CNT_W-1:0] table_count_q;
  result_t                    exp_fifo [EXP_DEPTH];
  int                         exp_wr;
  int                         exp_rd;
  step_t                      steps [STEP_MAX];
  int                         n_steps;
  int                         mismatch_count;
  int                         item_count;
  bit                         steady;
  int                         rx_stall;
  result_t                    rx_exp;

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [tkms_pkg::KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // binary search over the mirrored table, same probe order as the core
  function automatic result_t search_table(input logic [tkms_pkg::KEY_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    int      span;
    result_t r;
    r = NO_MATCH;
    span = (table_count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count_q);
    lo = 0;
    hi = span - 1;
    while (hi >= lo) begin
      mid = (lo + hi) / 2;
      if (key > key_mem[mid]) begin
        lo = mid + 1;
      end else if (key < key_mem[mid]) begin
        hi = mid - 1;
      end else begin
        r.found = 1'b1;
        r.match_slot = tkms_pkg::SLOT_W'(mid);
        break;
      end
    end
    return r;
  endfunction

  task automatic add_step(input step_t s);
    steps[n_steps] = s;
    n_steps++;
  endtask

  task automatic send_txn(input logic kind, input logic [tkms_pkg::SLOT_W-1:0] slot,
                          input logic [tkms_pkg::KEY_W-1:0] key, input logic typed,
                          input result_t typed_exp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.kind        <= kind;
    req.entry_slot  <= slot;
    req.class_index <= key[63:48];
    req.name_index  <= key[47:16];
    req.proto_index <= key[15:0];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (kind == tkms_pkg::KIND_WRITE) begin
      key_mem[slot] = key;
    end else begin
      exp_fifo[exp_wr % EXP_DEPTH] = typed ? typed_exp : search_table(key);
      exp_wr++;
    end
    item_count++;
  endtask

  task automatic drain_results(input int settle);
    req.valid <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_count(input logic [tkms_pkg::CNT_W-1:0] value);
    drain_results(40);
    cfg_we        <= 1'b1;
    cfg_wdata     <= value;
    table_count_q = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // write outside the searched range, never read by a lookup
  task automatic write_spare(input int cnt);
    if (cnt < TABLE_DEPTH) begin
      send_txn(tkms_pkg::KIND_WRITE,
               tkms_pkg::SLOT_W'($urandom_range(cnt, TABLE_DEPTH - 1)), rand64(), 1'b0,
               NO_MATCH);
    end
  endtask

  task automatic fill_table(input int cnt, input bit sorted);
    logic [tkms_pkg::KEY_W-1:0] cur;
    logic [tkms_pkg::KEY_W-1:0] span;
    logic [tkms_pkg::KEY_W-1:0] stride;
    cur = ($urandom_range(0, 3) == 0) ? '0 : (rand64() >> $urandom_range(1, 20));
    span = (KEY_MAX - cur) / (cnt + 1);
    for (int i = 0; i < cnt; i++) begin
      if (sorted) begin
        case ($urandom_range(0, 9))
          0: stride = '0;
          1, 2, 3: stride = (span < 3) ? span : tkms_pkg::KEY_W'($urandom_range(1, 3));
          default: stride = rand64() % (span + 1);
        endcase
        cur = cur + stride;
      end else begin
        case ($urandom_range(0, 9))
          0: cur = '0;
          1: cur = KEY_MAX;
          default: cur = rand64();
        endcase
      end
      send_txn(tkms_pkg::KIND_WRITE, tkms_pkg::SLOT_W'(i), cur, 1'b0, NO_MATCH);
      if ($urandom_range(0, 7) == 0) write_spare(cnt);
    end
  endtask

  task automatic run_lookups(input int n, input int cnt);
    int                         lim;
    logic [tkms_pkg::KEY_W-1:0] key;
    lim = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
    for (int i = 0; i < n; i++) begin
      if (lim == 0) key = rand64();
      else key = key_mem[$urandom_range(0, lim - 1)];
      case ($urandom_range(0, 9))
        5: key = key + 1;
        6: key = key - 1;
        7, 8: key = rand64();
        9: key = $urandom_range(0, 1) ? KEY_MAX : '0;
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) write_spare(lim);
      if ($urandom_range(0, 39) == 0) drain_results(0);
      send_txn(tkms_pkg::KIND_LOOKUP, tkms_pkg::SLOT_W'($urandom), key, 1'b0, NO_MATCH);
    end
  endtask

  // result channel: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) begin
      if (exp_wr == exp_rd) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: found=%0b match_slot=%0d",
                   rsp.found, rsp.match_slot);
      end else begin
        rx_exp = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (rsp.found !== rx_exp.found || rsp.match_slot !== rx_exp.match_slot) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected found=%0b match_slot=%0d, %s%0b match_slot=%0d",
                     rx_exp.found, rx_exp.match_slot, "got found=",
                     rsp.found, rsp.match_slot);
        end
      end
    end
    if (steady || rx_stall == 0) begin
      rsp.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) rx_stall = pick_stall();
    end else begin
      rsp.ready <= 1'b0;
      rx_stall--;
    end
  end

  initial begin
    int cnt;
    int r;
    bit full_done;
    int phase;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req.valid       = 1'b0;
    req.kind        = tkms_pkg::KIND_WRITE;
    req.entry_slot  = '0;
    req.class_index = '0;
    req.name_index  = '0;
    req.proto_index = '0;
    rsp.ready       = 1'b0;
    table_count_q   = '0;
    exp_wr          = 0;
    exp_rd          = 0;
    n_steps         = 0;
    mismatch_count  = 0;
    item_count      = 0;
    steady          = 1'b0;
    rx_stall        = 0;
    full_done       = 1'b0;

    add_step('{OP_COUNT, 10'd0, 64'd0, 11'd0, 1'b0, NO_MATCH});
    add_step('{OP_LOOKUP, 10'h3FF, 64'd0, 11'd0, 1'b1, NO_MATCH});
    add_step('{OP_LOOKUP, 10'h000, KEY_MAX, 11'd0, 1'b1, NO_MATCH});
    add_step('{OP_WRITE, 10'd0, 64'd0, 11'd0, 1'b0, NO_MATCH});
    add_step('{OP_WRITE, 10'd1, 64'd1, 11'd0, 1'b0, NO_MATCH});
    add_step('{OP_WRITE, 10'd2, {16'h0000, 32'hFFFF_FFFF, 16'h0000}, 11'd0, 1'b0,
               NO_MATCH});
    add_step('{OP_WRITE, 10'd3, {16'h0001, 32'h0000_0000, 16'h0000}, 11'd0, 1'b0,
               NO_MATCH});
    add_step('{OP_WRITE, 10'd4, {16'h7FFF, 32'h1234_5678, 16'hABCD}, 11'd0, 1'b0,
               NO_MATCH});
    add_step('{OP_WRITE, 10'd5, {16'h8000, 32'h8000_0000, 16'h8000}, 11'd0, 1'b0,
               NO_MATCH});
    add_step('{OP_WRITE, 10'd6, {16'hFFFF, 32'hFFFF_FFFF, 16'hFFFE}, 11'd0, 1'b0,
               NO_MATCH});
    add_step('{OP_WRITE, 10'd7, KEY_MAX, 11'd0, 1'b0, NO_MATCH});
    add_step('{OP_COUNT, 10'd0, 64'd0, 11'd8, 1'b0, NO_MATCH});
    add_step('{OP_LOOKUP, 10'h155, 64'd0, 11'd0, 1'b1, '{1'b1, 10'd0}});
    add_step('{OP_LOOKUP, 10'h2AA, KEY_MAX, 11'd0, 1'b1, '{1'b1, 10'd7}});
    add_step('{OP_LOOKUP, 10'h000, {16'h8000, 32'h8000_0000, 16'h8000}, 11'd0, 1'b1,
               '{1'b1, 10'd5}});
    add_step('{OP_LOOKUP, 10'h3FF, {16'h0000, 32'hFFFF_FFFF, 16'h0000}, 11'd0, 1'b1,
               '{1'b1, 10'd2}});
    add_step('{OP_LOOKUP, 10'h001, 64'd2, 11'd0, 1'b0, NO_MATCH});
    add_step('{OP_LOOKUP, 10'h200, {16'hFFFF, 32'hFFFF_FFFF, 16'hFFFD}, 11'd0, 1'b0,
               NO_MATCH});
    add_step('{OP_COUNT, 10'd0, 64'd0, 11'd1, 1'b0, NO_MATCH});
    add_step('{OP_LOOKUP, 10'h0F0, 64'd0, 11'd0, 1'b1, '{1'b1, 10'd0}});
    add_step('{OP_LOOKUP, 10'h00F, 64'd1, 11'd0, 1'b1, NO_MATCH});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < n_steps; i++) begin
      case (steps[i].op)
        OP_COUNT: set_count(steps[i].cnt);
        OP_WRITE: send_txn(tkms_pkg::KIND_WRITE, steps[i].slot, steps[i].key, 1'b0,
                           NO_MATCH);
        default:  send_txn(tkms_pkg::KIND_LOOKUP, steps[i].slot, steps[i].key,
                           steps[i].typed, steps[i].exp);
      endcase
    end

    item_count = 0;
    phase = 0;
    while (item_count < 600 || !full_done) begin
      steady = ($urandom_range(0, 4) == 0);
      if (phase == 3) begin
        // full table, then counts at and beyond the table depth
        set_count(11'd0);
        fill_table(TABLE_DEPTH, 1'b1);
        item_count -= TABLE_DEPTH;
        set_count(11'd1024);
        run_lookups(20, TABLE_DEPTH);
        set_count(11'd2047);
        run_lookups(15, TABLE_DEPTH);
        set_count(11'd1025);
        run_lookups(15, TABLE_DEPTH);
        full_done = 1'b1;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) cnt = 0;
        else if (r <= 10) cnt = $urandom_range(1, 8);
        else if (r <= 16) cnt = $urandom_range(9, 40);
        else cnt = $urandom_range(41, 120);
        set_count(11'd0);
        fill_table(cnt, $urandom_range(0, 4) != 0);
        set_count(tkms_pkg::CNT_W'(cnt));
        run_lookups($urandom_range(8, 30), cnt);
      end
      phase++;
    end

    steady = 1'b0;
    drain_results(50);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tkms_pkg.sv
rtl/core/tkms_if.sv
rtl/core/tkms_ctrl.sv
rtl/core/tkms_dp.sv
rtl/core/triple_key_method_table_search_core.sv
tb/testbench.sv
